>>> rtl/serial_memory_command_parser_defines.svh
// Assertion macros for the serial memory command parser.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef SERIAL_MEMORY_COMMAND_PARSER_DEFINES_SVH
`define SERIAL_MEMORY_COMMAND_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SMCP_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SMCP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/smcp_pkg.sv
// Shared types, character codes and reply text for the serial memory command parser.
// No dependencies.
`timescale 1ns / 1ps

package smcp_pkg;

    // Command parser position
    typedef enum logic [2:0] {
        P_CMD    = 3'd0,
        P_RADDR  = 3'd1,
        P_RCOUNT = 3'd2,
        P_WADDR  = 3'd3,
        P_WDATA  = 3'd4
    } parse_t;

    // Reply sequencer
    typedef enum logic [2:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_RD,
        SEQ_RD_WAIT,
        SEQ_MSG,
        SEQ_CR
    } seq_t;

    // Error reply selection
    typedef enum logic [1:0] {
        MSG_UNKNOWN,
        MSG_RANGE,
        MSG_STATE
    } msg_t;

    localparam int unsigned ACC_W     = 9;
    localparam int unsigned MSG_IDX_W = 5;

    localparam logic [ACC_W-1:0] ACC_LIMIT = 9'd256;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_R_UP   = 8'h52;
    localparam logic [7:0] CH_R_LOW  = 8'h72;
    localparam logic [7:0] CH_W_UP   = 8'h57;
    localparam logic [7:0] CH_W_LOW  = 8'h77;

    localparam int unsigned UNKNOWN_LEN = 23;
    localparam int unsigned RANGE_LEN   = 14;
    localparam int unsigned STATE_LEN   = 17;

    localparam logic [8*UNKNOWN_LEN-1:0] UNKNOWN_TXT = "Comando no identificado";
    localparam logic [8*RANGE_LEN-1:0]   RANGE_TXT   = "Fuera de rango";
    localparam logic [8*STATE_LEN-1:0]   STATE_TXT   = "Estado inesperado";

    // Decimal accumulate: acc*10 + d, saturating at 256
    function automatic logic [ACC_W-1:0] acc_digit(logic [ACC_W-1:0] acc, logic [3:0] d);
        logic [11:0] v;
        v = {acc, 3'b000} + {2'b00, acc, 1'b0} + {8'h00, d};
        return (v > 12'(ACC_LIMIT)) ? ACC_LIMIT : v[ACC_W-1:0];
    endfunction

    // Index of the final text character of a message
    function automatic logic [MSG_IDX_W-1:0] msg_last(msg_t kind);
        logic [MSG_IDX_W-1:0] n;
        unique case (kind)
            MSG_UNKNOWN: n = MSG_IDX_W'(UNKNOWN_LEN - 1);
            MSG_RANGE:   n = MSG_IDX_W'(RANGE_LEN - 1);
            MSG_STATE:   n = MSG_IDX_W'(STATE_LEN - 1);
            default:     n = '0;
        endcase
        return n;
    endfunction

    // Character idx of a message, first character at idx 0
    function automatic logic [7:0] msg_char(msg_t kind, logic [MSG_IDX_W-1:0] idx);
        logic [7:0] c;
        c = CH_CR;
        unique case (kind)
            MSG_UNKNOWN:
            begin
                if (int'(idx) < UNKNOWN_LEN)
                begin
                    c = UNKNOWN_TXT[8*(UNKNOWN_LEN-1-int'(idx)) +: 8];
                end
            end
            MSG_RANGE:
            begin
                if (int'(idx) < RANGE_LEN)
                begin
                    c = RANGE_TXT[8*(RANGE_LEN-1-int'(idx)) +: 8];
                end
            end
            MSG_STATE:
            begin
                if (int'(idx) < STATE_LEN)
                begin
                    c = STATE_TXT[8*(STATE_LEN-1-int'(idx)) +: 8];
                end
            end
            default: c = CH_CR;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/serial_memory_command_parser.sv
// Channel  | Direction | Handshake          | Payload
// rx       | in        | rx_valid/rx_stall  | rx_byte[7:0]
// tx       | out       | tx_valid/tx_stall  | tx_byte[7:0], last
//
// A request on rx is accepted whenever the block is idle, and the parse runs in the same cycle.
// A read reply fetches each data byte from the RAM (one read port, registered read), then sends it,
// and closes the run with the CR, also when a zero byte stops it early;
// an error reply sends each character of its message, then the CR.
// After reset the store is cleared one entry a cycle, all STORE_DEPTH entries, with rx stalled.
// rx is stalled while a reply is produced; tx stall holds the output register and pauses
// the reply sequencer.
// Depends on smcp_pkg, smcp_ram and serial_memory_command_parser_defines.svh.
`timescale 1ns / 1ps
`include "serial_memory_command_parser_defines.svh"

module serial_memory_command_parser #(
    parameter int BUFFER_DEPTH = 64,
    parameter int STORE_DEPTH  = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       tx_valid,
    input  logic       tx_stall,
    output logic [7:0] tx_byte,
    output logic       last
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int AC = smcp_pkg::ACC_W;
    localparam int MI = smcp_pkg::MSG_IDX_W;

    // Parser registers
    smcp_pkg::parse_t parse_reg, parse_next;
    logic [AC-1:0]    addr_acc_reg, addr_acc_next;
    logic [AC-1:0]    cnt_acc_reg, cnt_acc_next;
    logic [CW-1:0]    wr_idx_reg, wr_idx_next;
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;

    // Sequencer registers
    smcp_pkg::seq_t   seq_reg, seq_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    rem_reg, rem_next;
    smcp_pkg::msg_t   msg_reg, msg_next;
    logic [MI-1:0]    msg_idx_reg, msg_idx_next;
    logic [AW-1:0]    clr_ptr_reg, clr_ptr_next;

    // Output register
    logic             tx_valid_reg;
    logic [7:0]       tx_byte_reg;
    logic             last_reg;

    // Decode and control
    logic             accept;
    logic             is_digit;
    logic [7:0]       digit_full;
    logic [AC-1:0]    acc_new_addr;
    logic [AC-1:0]    acc_new_cnt;
    logic             addr_bad;
    logic             cnt_bad;
    logic             wr_room;
    logic [AW-1:0]    wr_ptr_inc;
    logic             out_free;
    logic             start_read;
    logic             start_err;
    smcp_pkg::msg_t   err_kind;
    logic             data_we;
    logic             clr_we;
    logic             push;
    logic [7:0]       push_byte;
    logic             push_last;

    // RAM port
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [7:0]       ram_wdata;
    logic             ram_re;
    logic [7:0]       ram_rdata;

    assign accept       = rx_valid && !rx_stall;
    assign is_digit     = (rx_byte >= smcp_pkg::CH_ZERO) && (rx_byte <= smcp_pkg::CH_NINE);
    assign digit_full   = rx_byte - smcp_pkg::CH_ZERO;
    assign acc_new_addr = smcp_pkg::acc_digit(addr_acc_reg, digit_full[3:0]);
    assign acc_new_cnt  = smcp_pkg::acc_digit(cnt_acc_reg, digit_full[3:0]);
    assign addr_bad     = addr_acc_reg > AC'(STORE_DEPTH - 1);
    assign cnt_bad      = (cnt_acc_reg > AC'(BUFFER_DEPTH - 1))
                       || (({1'b0, addr_acc_reg} + {1'b0, cnt_acc_reg}) > (AC+1)'(STORE_DEPTH - 1));
    assign wr_room      = wr_idx_reg < CW'(BUFFER_DEPTH);
    assign wr_ptr_inc   = (wr_ptr_reg == AW'(STORE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign out_free     = !tx_valid_reg || !tx_stall;

    // Command parser: acts on each accepted request
    always_comb
    begin
        parse_next    = parse_reg;
        addr_acc_next = addr_acc_reg;
        cnt_acc_next  = cnt_acc_reg;
        wr_idx_next   = wr_idx_reg;
        wr_ptr_next   = wr_ptr_reg;
        start_read    = 1'b0;
        start_err     = 1'b0;
        err_kind      = smcp_pkg::MSG_UNKNOWN;
        data_we       = 1'b0;
        if (accept)
        begin
            unique case (parse_reg)
                smcp_pkg::P_CMD:
                begin
                    if (rx_byte == smcp_pkg::CH_R_UP || rx_byte == smcp_pkg::CH_R_LOW)
                    begin
                        parse_next = smcp_pkg::P_RADDR;
                    end
                    else if (rx_byte == smcp_pkg::CH_W_UP || rx_byte == smcp_pkg::CH_W_LOW)
                    begin
                        parse_next = smcp_pkg::P_WADDR;
                    end
                    else
                    begin
                        start_err = 1'b1;
                        err_kind  = smcp_pkg::MSG_UNKNOWN;
                    end
                end
                smcp_pkg::P_RADDR, smcp_pkg::P_WADDR:
                begin
                    if (is_digit)
                    begin
                        addr_acc_next = acc_new_addr;
                    end
                    else if (addr_bad)
                    begin
                        start_err = 1'b1;
                        err_kind  = smcp_pkg::MSG_RANGE;
                    end
                    else if (parse_reg == smcp_pkg::P_RADDR)
                    begin
                        parse_next = smcp_pkg::P_RCOUNT;
                    end
                    else
                    begin
                        parse_next  = smcp_pkg::P_WDATA;
                        wr_ptr_next = addr_acc_reg[AW-1:0];
                        wr_idx_next = '0;
                    end
                end
                smcp_pkg::P_RCOUNT:
                begin
                    if (is_digit)
                    begin
                        cnt_acc_next = acc_new_cnt;
                    end
                    else if (cnt_bad)
                    begin
                        start_err = 1'b1;
                        err_kind  = smcp_pkg::MSG_RANGE;
                    end
                    else
                    begin
                        start_read    = 1'b1;
                        parse_next    = smcp_pkg::P_CMD;
                        addr_acc_next = '0;
                        cnt_acc_next  = '0;
                    end
                end
                smcp_pkg::P_WDATA:
                begin
                    if (rx_byte != smcp_pkg::CH_DOLLAR)
                    begin
                        if (wr_room)
                        begin
                            data_we     = 1'b1;
                            wr_ptr_next = wr_ptr_inc;
                            wr_idx_next = wr_idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        parse_next    = smcp_pkg::P_CMD;
                        addr_acc_next = '0;
                    end
                end
                default:
                begin
                    start_err = 1'b1;
                    err_kind  = smcp_pkg::MSG_STATE;
                end
            endcase
            // every error returns to command wait and clears the numbers
            if (start_err)
            begin
                parse_next    = smcp_pkg::P_CMD;
                addr_acc_next = '0;
                cnt_acc_next  = '0;
            end
        end
    end

    // Sequencer next state
    always_comb
    begin
        seq_next     = seq_reg;
        rd_ptr_next  = rd_ptr_reg;
        rem_next     = rem_reg;
        msg_next     = msg_reg;
        msg_idx_next = msg_idx_reg;
        clr_ptr_next = clr_ptr_reg;
        unique case (seq_reg)
            smcp_pkg::SEQ_CLEAR:
            begin
                clr_ptr_next = clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == AW'(STORE_DEPTH - 1))
                begin
                    seq_next = smcp_pkg::SEQ_IDLE;
                end
            end
            smcp_pkg::SEQ_IDLE:
            begin
                if (start_read)
                begin
                    rd_ptr_next = addr_acc_reg[AW-1:0];
                    rem_next    = cnt_acc_reg[CW-1:0];
                    seq_next    = smcp_pkg::SEQ_RD;
                end
                else if (start_err)
                begin
                    msg_next     = err_kind;
                    msg_idx_next = '0;
                    seq_next     = smcp_pkg::SEQ_MSG;
                end
            end
            smcp_pkg::SEQ_RD:
            begin
                seq_next = (rem_reg == '0) ? smcp_pkg::SEQ_CR : smcp_pkg::SEQ_RD_WAIT;
            end
            smcp_pkg::SEQ_RD_WAIT:
            begin
                if (ram_rdata == 8'h00)
                begin
                    seq_next = smcp_pkg::SEQ_CR;
                end
                else if (out_free)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    rem_next    = rem_reg - 1'b1;
                    seq_next    = smcp_pkg::SEQ_RD;
                end
            end
            smcp_pkg::SEQ_MSG:
            begin
                if (out_free)
                begin
                    if (msg_idx_reg == smcp_pkg::msg_last(msg_reg))
                    begin
                        seq_next = smcp_pkg::SEQ_CR;
                    end
                    else
                    begin
                        msg_idx_next = msg_idx_reg + 1'b1;
                    end
                end
            end
            smcp_pkg::SEQ_CR:
            begin
                if (out_free)
                begin
                    seq_next = smcp_pkg::SEQ_IDLE;
                end
            end
            default: seq_next = smcp_pkg::SEQ_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        rx_stall  = (seq_reg != smcp_pkg::SEQ_IDLE);
        clr_we    = 1'b0;
        ram_re    = 1'b0;
        push      = 1'b0;
        push_byte = smcp_pkg::CH_CR;
        push_last = 1'b0;
        unique case (seq_reg)
            smcp_pkg::SEQ_CLEAR:   clr_we = 1'b1;
            smcp_pkg::SEQ_IDLE:    ;
            smcp_pkg::SEQ_RD:      ram_re = (rem_reg != '0);
            smcp_pkg::SEQ_RD_WAIT:
            begin
                push      = out_free && (ram_rdata != 8'h00);
                push_byte = ram_rdata;
            end
            smcp_pkg::SEQ_MSG:
            begin
                push      = out_free;
                push_byte = smcp_pkg::msg_char(msg_reg, msg_idx_reg);
            end
            smcp_pkg::SEQ_CR:
            begin
                push      = out_free;
                push_byte = smcp_pkg::CH_CR;
                push_last = 1'b1;
            end
            default: ;
        endcase
    end

    // RAM write source: clearing pass or write data
    assign ram_we    = clr_we || data_we;
    assign ram_waddr = clr_we ? clr_ptr_reg : wr_ptr_reg;
    assign ram_wdata = clr_we ? 8'h00 : rx_byte;

    smcp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg    <= smcp_pkg::P_CMD;
            addr_acc_reg <= '0;
            cnt_acc_reg  <= '0;
            wr_idx_reg   <= '0;
            wr_ptr_reg   <= '0;
            seq_reg      <= smcp_pkg::SEQ_CLEAR;
            rd_ptr_reg   <= '0;
            rem_reg      <= '0;
            msg_reg      <= smcp_pkg::MSG_UNKNOWN;
            msg_idx_reg  <= '0;
            clr_ptr_reg  <= '0;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            parse_reg    <= parse_next;
            addr_acc_reg <= addr_acc_next;
            cnt_acc_reg  <= cnt_acc_next;
            wr_idx_reg   <= wr_idx_next;
            wr_ptr_reg   <= wr_ptr_next;
            seq_reg      <= seq_next;
            rd_ptr_reg   <= rd_ptr_next;
            rem_reg      <= rem_next;
            msg_reg      <= msg_next;
            msg_idx_reg  <= msg_idx_next;
            clr_ptr_reg  <= clr_ptr_next;
            if (push)
            begin
                tx_valid_reg <= 1'b1;
            end
            else if (!tx_stall)
            begin
                tx_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            tx_byte_reg <= push_byte;
            last_reg    <= push_last;
        end
    end

    assign tx_valid = tx_valid_reg;
    assign tx_byte  = tx_byte_reg;
    assign last     = last_reg;

    // Checks
    `SMCP_ASSERT_NOW(a_last_is_cr, tx_valid && last, tx_byte == smcp_pkg::CH_CR, "run end is not CR")
    `SMCP_ASSERT_NOW(a_read_issued, seq_reg == smcp_pkg::SEQ_RD_WAIT, $past(seq_reg) == smcp_pkg::SEQ_RD || $past(seq_reg) == smcp_pkg::SEQ_RD_WAIT, "read data used without a read")
    `SMCP_ASSERT_NEXT(a_read_starts, accept && parse_reg == smcp_pkg::P_RCOUNT && !is_digit && !cnt_bad, seq_reg == smcp_pkg::SEQ_RD && parse_reg == smcp_pkg::P_CMD, "valid read did not start")

endmodule

>>> rtl/smcp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module smcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
